>>> rtl/core/bta_pkg.sv
// ----------------------------------------------------------------------------
// bta_pkg: shared constants, types and helpers for the bulge-to-arc pipeline
// Holds latencies, datapath widths, the arctangent table and side-data types.
// ----------------------------------------------------------------------------
`default_nettype none

package bta_pkg;

  // CORDIC iterations requested, and the count actually built (24 at most)
  localparam int ANGLE_STEPS  = 16;
  localparam int CORDIC_ITERS = (ANGLE_STEPS > 24) ? 24 : ANGLE_STEPS;

  // Stage counts of the pipeline parts
  localparam int DIV_LAT    = 31;
  localparam int SQRT_STEPS = 32;
  localparam int RAD_LAT    = SQRT_STEPS + 3;
  localparam int COR_LAT    = CORDIC_ITERS + 2;
  localparam int PAD_LAT    = RAD_LAT - COR_LAT;
  localparam int PIPE_LAT   = DIV_LAT + RAD_LAT + 5;

  // Datapath widths: centre, centre-to-point vector, CORDIC working range
  localparam int CEN_W  = 50;
  localparam int VEC_W  = 51;
  localparam int CORD_W = 54;

  // atan(2^-i) as 32-bit binary angle
  localparam logic [31:0] ATAN_TAB [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Data that rides alongside the divider
  typedef struct packed {
    logic               bad;
    logic               bneg;
    logic               cneg;
    logic signed [31:0] mid_x;
    logic signed [31:0] mid_y;
    logic signed [32:0] dxy;
    logic signed [32:0] dyx;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
  } div_side_t;

  // Data that rides alongside the radius unit
  typedef struct packed {
    logic        bad;
    logic        bneg;
    logic [31:0] cen_x;
    logic [31:0] cen_y;
  } rad_side_t;

  typedef struct packed {
    logic [15:0] sa;
    logic [15:0] ea;
  } ang_pair_t;

  // Clamp a wide signed value to the int32 range
  function automatic logic [31:0] sat32(logic signed [CEN_W-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[CEN_W-1:31];
    all_zero = ~(|v[CEN_W-1:31]);
    if (all_one || all_zero) begin
      return v[31:0];
    end else if (v[CEN_W-1]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/bta_div.sv
// ----------------------------------------------------------------------------
// bta_div: pipelined restoring divider for the cotangent term
// One quotient bit per stage; the quotient is known to fit in 31 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module bta_div import bta_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [32:0] rem_i,   // dividend bits above the low 31, below divisor
  input  logic [30:0] nlow_i,  // low 31 dividend bits
  input  logic [32:0] dvs_i,   // divisor
  output logic [30:0] quo_o
);

  logic [32:0] rem_q [DIV_LAT];
  logic [32:0] rem_d [DIV_LAT];
  logic [30:0] nl_q  [DIV_LAT];
  logic [30:0] nl_d  [DIV_LAT];
  logic [32:0] dv_q  [DIV_LAT];
  logic [32:0] dv_d  [DIV_LAT];
  logic [30:0] qu_q  [DIV_LAT];
  logic [30:0] qu_d  [DIV_LAT];

  // One compare-subtract per stage
  always_comb begin
    logic [32:0] rem_p;
    logic [30:0] nl_p;
    logic [32:0] dv_p;
    logic [30:0] qu_p;
    logic [33:0] trial;
    logic        ge;
    for (int k = 0; k < DIV_LAT; k++) begin
      if (k == 0) begin
        rem_p = rem_i;
        nl_p  = nlow_i;
        dv_p  = dvs_i;
        qu_p  = '0;
      end else begin
        rem_p = rem_q[k-1];
        nl_p  = nl_q[k-1];
        dv_p  = dv_q[k-1];
        qu_p  = qu_q[k-1];
      end
      trial    = {rem_p, nl_p[DIV_LAT-1-k]};
      ge       = trial >= {1'b0, dv_p};
      rem_d[k] = ge ? 33'(trial - {1'b0, dv_p}) : trial[32:0];
      nl_d[k]  = nl_p;
      dv_d[k]  = dv_p;
      qu_d[k]  = {qu_p[29:0], ge};
    end
  end

  // Advance all stages together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        rem_q[k] <= rem_d[k];
        nl_q[k]  <= nl_d[k];
        dv_q[k]  <= dv_d[k];
        qu_q[k]  <= qu_d[k];
      end
    end
  end

  assign quo_o = qu_q[DIV_LAT-1];

endmodule

`default_nettype wire

>>> rtl/core/bta_sqrt.sv
// ----------------------------------------------------------------------------
// bta_sqrt: radius unit, floor(sqrt(vx^2 + vy^2)) with saturation
// Magnitude, squares and sum take three stages, then one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bta_sqrt import bta_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [VEC_W-1:0] vx_i,
  input  logic signed [VEC_W-1:0] vy_i,
  output logic [31:0]             radius_o
);

  logic [VEC_W-1:0] ax;
  logic [VEC_W-1:0] ay;
  logic [31:0]      ax_q, ay_q;
  logic             ova_q, ovb_q, ovc_q;
  logic [63:0]      sqx_q, sqy_q;
  logic [64:0]      sum;
  logic [64:0]      sum_q;

  logic [33:0] rm_q [SQRT_STEPS];
  logic [33:0] rm_d [SQRT_STEPS];
  logic [31:0] rt_q [SQRT_STEPS];
  logic [31:0] rt_d [SQRT_STEPS];
  logic [63:0] n_q  [SQRT_STEPS];
  logic [63:0] n_d  [SQRT_STEPS];
  logic        ov_q [SQRT_STEPS];
  logic        ov_d [SQRT_STEPS];

  // Magnitudes; anything at or above 2^32 saturates the radius
  assign ax  = vx_i[VEC_W-1] ? VEC_W'(-vx_i) : VEC_W'(vx_i);
  assign ay  = vy_i[VEC_W-1] ? VEC_W'(-vy_i) : VEC_W'(vy_i);
  assign sum = 65'(sqx_q) + 65'(sqy_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q  <= ax[31:0];
      ay_q  <= ay[31:0];
      ova_q <= (|ax[VEC_W-1:32]) | (|ay[VEC_W-1:32]);
      sqx_q <= 64'(ax_q) * 64'(ax_q);
      sqy_q <= 64'(ay_q) * 64'(ay_q);
      ovb_q <= ova_q;
      sum_q <= sum;
      ovc_q <= ovb_q;
    end
  end

  // Digit-by-digit root, two radicand bits per stage
  always_comb begin
    logic [33:0] rm_p;
    logic [31:0] rt_p;
    logic [63:0] n_p;
    logic        ov_p;
    logic [35:0] trial;
    logic [35:0] tst;
    logic        ge;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (k == 0) begin
        rm_p = '0;
        rt_p = '0;
        n_p  = sum_q[63:0];
        ov_p = ovc_q | sum_q[64];
      end else begin
        rm_p = rm_q[k-1];
        rt_p = rt_q[k-1];
        n_p  = n_q[k-1];
        ov_p = ov_q[k-1];
      end
      trial   = {rm_p, n_p[63-2*k], n_p[62-2*k]};
      tst     = {2'b00, rt_p, 2'b01};
      ge      = trial >= tst;
      rm_d[k] = ge ? 34'(trial - tst) : trial[33:0];
      rt_d[k] = {rt_p[30:0], ge};
      n_d[k]  = n_p;
      ov_d[k] = ov_p;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
        rm_q[k] <= rm_d[k];
        rt_q[k] <= rt_d[k];
        n_q[k]  <= n_d[k];
        ov_q[k] <= ov_d[k];
      end
    end
  end

  assign radius_o = ov_q[SQRT_STEPS-1] ? '1 : rt_q[SQRT_STEPS-1];

endmodule

`default_nettype wire

>>> rtl/core/bta_cordic.sv
// ----------------------------------------------------------------------------
// bta_cordic: pipelined vectoring CORDIC giving a 16-bit binary angle
// Half-turn pre-rotation, one micro-rotation per stage, then rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module bta_cordic import bta_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [VEC_W-1:0] vx_i,
  input  logic signed [VEC_W-1:0] vy_i,
  output logic [15:0]             angle_o
);

  logic signed [CORD_W-1:0] x_q [CORDIC_ITERS+1];
  logic signed [CORD_W-1:0] x_d [CORDIC_ITERS+1];
  logic signed [CORD_W-1:0] y_q [CORDIC_ITERS+1];
  logic signed [CORD_W-1:0] y_d [CORDIC_ITERS+1];
  logic [31:0]              acc_q [CORDIC_ITERS+1];
  logic [31:0]              acc_d [CORDIC_ITERS+1];
  logic                     zero_q [CORDIC_ITERS+1];
  logic                     zero_d [CORDIC_ITERS+1];
  logic [15:0]              ang_q;
  logic [31:0]              rnd;

  always_comb begin
    logic signed [CORD_W-1:0] dx;
    logic signed [CORD_W-1:0] dy;
    // Pre-rotate by a half turn when x is negative
    zero_d[0] = (vx_i == '0) && (vy_i == '0);
    if (vx_i[VEC_W-1]) begin
      x_d[0]   = -CORD_W'(vx_i);
      y_d[0]   = -CORD_W'(vy_i);
      acc_d[0] = 32'h8000_0000;
    end else begin
      x_d[0]   = CORD_W'(vx_i);
      y_d[0]   = CORD_W'(vy_i);
      acc_d[0] = '0;
    end
    // Rotate toward the x axis
    for (int k = 1; k <= CORDIC_ITERS; k++) begin
      dx = y_q[k-1] >>> (k-1);
      dy = x_q[k-1] >>> (k-1);
      if (y_q[k-1] > 0) begin
        x_d[k]   = x_q[k-1] + dx;
        y_d[k]   = y_q[k-1] - dy;
        acc_d[k] = acc_q[k-1] + ATAN_TAB[k-1];
      end else begin
        x_d[k]   = x_q[k-1] - dx;
        y_d[k]   = y_q[k-1] + dy;
        acc_d[k] = acc_q[k-1] - ATAN_TAB[k-1];
      end
      zero_d[k] = zero_q[k-1];
    end
  end

  // Round to 16 bits; a zero vector gives angle zero
  assign rnd = acc_q[CORDIC_ITERS] + 32'h0000_8000;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= CORDIC_ITERS; k++) begin
        x_q[k]    <= x_d[k];
        y_q[k]    <= y_d[k];
        acc_q[k]  <= acc_d[k];
        zero_q[k] <= zero_d[k];
      end
      ang_q <= zero_q[CORDIC_ITERS] ? '0 : rnd[31:16];
    end
  end

  assign angle_o = ang_q;

endmodule

`default_nettype wire

>>> rtl/core/bulge_to_arc_top.sv
// ----------------------------------------------------------------------------
// bulge_to_arc_top: polyline segment (start, end, bulge) to arc converter
// Centre, radius and start/end angles in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one segment per clock and returns one arc per segment, in
// order. The latency is set by the 31-stage cotangent divider and the
// 35-stage radius unit (three stages of squaring and summing, then a 32-stage
// square root); the two angle CORDICs run beside the root. The whole
// pipeline advances together and halts only while a result waits on the
// output.
`default_nettype none

module bulge_to_arc_top import bta_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // bulge[31:0], start_x[63:32], start_y[95:64], end_x[127:96], end_y[159:128]
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // center_x[31:0], center_y[63:32], radius[95:64],
  // first angle[111:96], last angle[127:112]
  output logic [127:0] m_axis_tdata,
  output logic         m_axis_tuser   // bad_bulge
);

  logic                en;
  logic [PIPE_LAT-1:0] vld_q;
  logic                m_vld_q;

  // Input stage
  logic signed [31:0] b_in;
  logic [31:0]        ab;
  logic signed [31:0] b_q, sx_q, sy_q, ex_q, ey_q;
  logic [31:0]        ab_q;
  logic [62:0]        bb_q;

  // Divider setup stage
  logic               over;
  logic [62:0]        mag;
  logic signed [32:0] sum_x, sum_y;
  div_side_t          side1;
  div_side_t          side1_q;
  logic [32:0]        r0_q, d_q;
  logic [30:0]        nlow_q;
  logic [30:0]        quo;
  div_side_t          dside_q [DIV_LAT];

  // Centre and vector stages
  div_side_t          side2;
  logic signed [31:0] cot;
  logic signed [64:0] px_q, py_q;
  div_side_t          side3_q, side4_q;
  logic signed [CEN_W-1:0] cx_q, cy_q;
  logic signed [VEC_W-1:0] vsx_q, vsy_q, vex_q, vey_q;
  rad_side_t          rside_q;
  rad_side_t          rsd_q [RAD_LAT];

  // Radius and angle results
  logic [31:0]        radius;
  logic [15:0]        sa_raw, ea_raw;
  ang_pair_t          apad_q [PAD_LAT];
  rad_side_t          rs_o;
  ang_pair_t          ap_o;
  logic [127:0]       tdata_q;
  logic               tuser_q;

  // Advance whenever the output register is free or being drained
  assign en            = m_axis_tready | ~m_vld_q;
  assign s_axis_tready = en;

  assign b_in = s_axis_tdata[31:0];
  assign ab   = b_in[31] ? 32'(32'd0 - b_in) : b_in;

  // Register the segment and square the bulge
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_q  <= b_in;
      sx_q <= s_axis_tdata[63:32];
      sy_q <= s_axis_tdata[95:64];
      ex_q <= s_axis_tdata[127:96];
      ey_q <= s_axis_tdata[159:128];
      ab_q <= ab;
      bb_q <= 63'(ab) * 63'(ab);
    end
  end

  // Form |2^32 - b*b|, divisor 2|b|, midpoint and chord deltas
  assign over  = bb_q > 63'h1_0000_0000;
  assign mag   = over ? 63'(bb_q - 63'h1_0000_0000) : 63'(63'h1_0000_0000 - bb_q);
  assign sum_x = 33'(sx_q) + 33'(ex_q);
  assign sum_y = 33'(sy_q) + 33'(ey_q);

  always_comb begin
    side1.bad   = (b_q == '0);
    side1.bneg  = b_q[31];
    side1.cneg  = over ^ b_q[31];
    side1.mid_x = sum_x[32:1];
    side1.mid_y = sum_y[32:1];
    side1.dxy   = 33'(sy_q) - 33'(ey_q);
    side1.dyx   = 33'(ex_q) - 33'(sx_q);
    side1.sx    = sx_q;
    side1.sy    = sy_q;
    side1.ex    = ex_q;
    side1.ey    = ey_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q <= side1;
      r0_q    <= {1'b0, mag[62:31]};
      nlow_q  <= mag[30:0];
      d_q     <= {ab_q, 1'b0};
    end
  end

  bta_div u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .rem_i  (r0_q),
    .nlow_i (nlow_q),
    .dvs_i  (d_q),
    .quo_o  (quo)
  );

  // Carry side data past the divider
  always_ff @(posedge clk_i) begin
    if (en) begin
      dside_q[0] <= side1_q;
      for (int k = 1; k < DIV_LAT; k++) begin
        dside_q[k] <= dside_q[k-1];
      end
    end
  end

  assign side2 = dside_q[DIV_LAT-1];
  assign cot   = side2.cneg ? 32'(32'sd0 - $signed({1'b0, quo})) : $signed({1'b0, quo});

  // Scale chord deltas by the cotangent, then add to the midpoint
  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q    <= 65'(side2.dxy) * 65'(cot);
      py_q    <= 65'(side2.dyx) * 65'(cot);
      side3_q <= side2;
      cx_q    <= CEN_W'(side3_q.mid_x) + CEN_W'(px_q >>> 17);
      cy_q    <= CEN_W'(side3_q.mid_y) + CEN_W'(py_q >>> 17);
      side4_q <= side3_q;
    end
  end

  // Vectors from the centre to both points; saturated centre for output
  always_ff @(posedge clk_i) begin
    if (en) begin
      vsx_q         <= VEC_W'(side4_q.sx) - VEC_W'(cx_q);
      vsy_q         <= VEC_W'(side4_q.sy) - VEC_W'(cy_q);
      vex_q         <= VEC_W'(side4_q.ex) - VEC_W'(cx_q);
      vey_q         <= VEC_W'(side4_q.ey) - VEC_W'(cy_q);
      rside_q.bad   <= side4_q.bad;
      rside_q.bneg  <= side4_q.bneg;
      rside_q.cen_x <= sat32(cx_q);
      rside_q.cen_y <= sat32(cy_q);
    end
  end

  bta_sqrt u_sqrt (
    .clk_i    (clk_i),
    .en_i     (en),
    .vx_i     (vsx_q),
    .vy_i     (vsy_q),
    .radius_o (radius)
  );

  bta_cordic u_cordic_s (
    .clk_i   (clk_i),
    .en_i    (en),
    .vx_i    (vsx_q),
    .vy_i    (vsy_q),
    .angle_o (sa_raw)
  );

  bta_cordic u_cordic_e (
    .clk_i   (clk_i),
    .en_i    (en),
    .vx_i    (vex_q),
    .vy_i    (vey_q),
    .angle_o (ea_raw)
  );

  // Align side data and angles with the radius
  always_ff @(posedge clk_i) begin
    if (en) begin
      rsd_q[0] <= rside_q;
      for (int k = 1; k < RAD_LAT; k++) begin
        rsd_q[k] <= rsd_q[k-1];
      end
      apad_q[0].sa <= sa_raw;
      apad_q[0].ea <= ea_raw;
      for (int k = 1; k < PAD_LAT; k++) begin
        apad_q[k] <= apad_q[k-1];
      end
    end
  end

  assign rs_o = rsd_q[RAD_LAT-1];
  assign ap_o = apad_q[PAD_LAT-1];

  // Output register: zero result on a bad bulge, swap angles when clockwise
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (rs_o.bad) begin
        tdata_q <= '0;
        tuser_q <= 1'b1;
      end else if (rs_o.bneg) begin
        tdata_q <= {ap_o.sa, ap_o.ea, radius, rs_o.cen_y, rs_o.cen_x};
        tuser_q <= 1'b0;
      end else begin
        tdata_q <= {ap_o.ea, ap_o.sa, radius, rs_o.cen_y, rs_o.cen_x};
        tuser_q <= 1'b0;
      end
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      m_vld_q <= 1'b0;
    end else if (en) begin
      vld_q   <= {vld_q[PIPE_LAT-2:0], s_axis_tvalid};
      m_vld_q <= vld_q[PIPE_LAT-1];
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

`ifndef SYNTHESIS
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("bad bulge result carries nonzero data");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> $stable(vld_q))
    else $error("pipeline moved during output stall");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a waiting result");
`endif

endmodule

`default_nettype wire
